@@ hdl/rctm_pkg.sv @@
// Package with shared widths, reset values and register codes of the RC trimmed mean filter.
`timescale 1ns / 1ps

package rctm_pkg;

  // Field widths fixed by the channel format.
  localparam int unsigned IN_W    = 16;
  localparam int unsigned VAL_W   = 13;
  localparam int unsigned NUM_IN  = 4;
  localparam int unsigned NUM_OUT = 4;

  // Default sizes of the filter.
  localparam int unsigned CHANNELS_DEF = 4;
  localparam int unsigned WINDOW_DEF   = 4;

  typedef logic [IN_W-1:0]  width_t;
  typedef logic [VAL_W-1:0] val_t;

  // Configuration register indexes.
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_LOW_LIMIT  = 1'b0;
  localparam cfg_idx_t CFG_HIGH_LIMIT = 1'b1;

  // Register values after reset.
  localparam val_t LOW_LIMIT_RST  = 13'd800;
  localparam val_t HIGH_LIMIT_RST = 13'd2800;

endpackage

@@ hdl/rctm_if.sv @@
// Stream interfaces for the sample input beats and the filtered result beats.
`timescale 1ns / 1ps

interface rctm_in_if;
  import rctm_pkg::*;

  logic   valid;
  logic   ready;
  width_t width_ch0;
  width_t width_ch1;
  width_t width_ch2;
  width_t width_ch3;

  modport source (output valid, output width_ch0, output width_ch1,
                  output width_ch2, output width_ch3, input ready);
  modport sink   (input valid, input width_ch0, input width_ch1,
                  input width_ch2, input width_ch3, output ready);
endinterface

interface rctm_out_if;
  import rctm_pkg::*;

  logic valid;
  logic ready;
  val_t yaw_out;
  val_t throttle_out;
  val_t roll_out;
  val_t pitch_out;

  modport source (output valid, output yaw_out, output throttle_out,
                  output roll_out, output pitch_out, input ready);
  modport sink   (input valid, input yaw_out, input throttle_out,
                  input roll_out, input pitch_out, output ready);
endinterface

@@ hdl/rc_channel_trimmed_mean_filter_core.sv @@
// Top level of the RC channel trimmed mean filter: limit check, windows and result register.
//
//   Channel   Direction  Payload                                      Beat
//   in_ch     sink       width_ch0..width_ch3, 16 bit each            one sample set
//   out_ch    source     yaw_out, throttle_out, roll_out, pitch_out   one filtered set
//   cfg_*     write      cfg_index selects low or high limit          one register write
//
// One beat is accepted per clock while the output register can take it; its result
// appears in the output register in the next cycle. The window update, max/min trim
// and halving are combinational between the window registers and the output register.
// A new beat is taken while the output register is empty or being read in the same cycle.
// Reset clears windows, last good samples and the slot counter, and loads the default limits.
`timescale 1ns / 1ps

module rc_channel_trimmed_mean_filter_core #(
  parameter int unsigned CHANNELS = rctm_pkg::CHANNELS_DEF,
  parameter int unsigned WINDOW   = rctm_pkg::WINDOW_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  rctm_pkg::cfg_idx_t cfg_index,
  input  rctm_pkg::val_t     cfg_data,
  rctm_in_if.sink            in_ch,
  rctm_out_if.source         out_ch
);
  import rctm_pkg::*;

  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SUM_W  = VAL_W + $clog2(WINDOW);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

  val_t              low_r;
  val_t              high_r;
  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W-1:0] slot_nxt;
  val_t              win_r     [CHANNELS][WINDOW];
  val_t              last_r    [CHANNELS];
  val_t              acc       [CHANNELS];
  val_t              filt      [CHANNELS];
  width_t            in_sample [NUM_IN];
  val_t              res_r     [NUM_OUT];
  val_t              res_nxt   [NUM_OUT];
  logic              out_valid_r;
  logic              in_fire;

  // Handshake: the output register frees up when it is empty or being read.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign in_sample[0] = in_ch.width_ch0;
  assign in_sample[1] = in_ch.width_ch1;
  assign in_sample[2] = in_ch.width_ch2;
  assign in_sample[3] = in_ch.width_ch3;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= LOW_LIMIT_RST;
      high_r <= HIGH_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOW_LIMIT:  low_r  <= cfg_data;
        CFG_HIGH_LIMIT: high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // The shared slot counter advances before each write.
  assign slot_nxt = (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else if (in_fire) begin
      slot_r <= slot_nxt;
    end
  end

  // Per-channel limit check, window update and trimmed sum.
  for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
    width_t sample;
    logic   in_range;

    if (c < NUM_IN) begin : g_src
      assign sample = in_sample[c];
    end else begin : g_zero
      assign sample = '0;
    end

    // Inclusive limits; a rejected sample repeats the last accepted one.
    assign in_range = (sample >= IN_W'(low_r)) && (sample <= IN_W'(high_r));
    assign acc[c]   = in_range ? sample[VAL_W-1:0] : last_r[c];

    // Sum, maximum and minimum over the window as it stands after this write.
    always_comb begin
      logic [SUM_W-1:0] sum;
      val_t             hi;
      val_t             lo;
      val_t             v;
      logic [SUM_W-1:0] trim;
      sum = '0;
      hi  = '0;
      lo  = '1;
      for (int k = 0; k < WINDOW; k++) begin
        v = (slot_nxt == SLOT_W'(k)) ? acc[c] : win_r[c][k];
        if (v > hi) begin
          hi = v;
        end
        if (v < lo) begin
          lo = v;
        end
        sum = sum + SUM_W'(v);
      end
      trim    = sum - SUM_W'(hi) - SUM_W'(lo);
      filt[c] = trim[VAL_W:1];
    end

    // Window and last good sample registers.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        last_r[c] <= '0;
        for (int k = 0; k < WINDOW; k++) begin
          win_r[c][k] <= '0;
        end
      end else if (in_fire) begin
        last_r[c] <= acc[c];
        for (int k = 0; k < WINDOW; k++) begin
          if (slot_nxt == SLOT_W'(k)) begin
            win_r[c][k] <= acc[c];
          end
        end
      end
    end
  end

  // Output fields: channels beyond the configured count read as zero.
  for (genvar o = 0; o < NUM_OUT; o++) begin : g_out
    if (o < CHANNELS) begin : g_live
      assign res_nxt[o] = filt[o];
    end else begin : g_none
      assign res_nxt[o] = '0;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int o = 0; o < NUM_OUT; o++) begin
        res_r[o] <= res_nxt[o];
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.yaw_out      = res_r[0];
  assign out_ch.throttle_out = res_r[1];
  assign out_ch.roll_out     = res_r[2];
  assign out_ch.pitch_out    = res_r[3];

endmodule

@@ tb/rc_channel_trimmed_mean_filter_core_tb.sv @@
// Self-checking testbench of the RC channel trimmed mean filter core.
`timescale 1ns / 1ps

module rc_channel_trimmed_mean_filter_core_tb;
  import rctm_pkg::*;

  localparam int unsigned NCH       = 4;
  localparam int unsigned NSLOT     = 4;
  localparam int unsigned STALL_LEN = 400;

  typedef struct packed {
    width_t [NCH-1:0] w;
  } frame_t;

  typedef struct packed {
    val_t yaw;
    val_t throttle;
    val_t roll;
    val_t pitch;
  } filt_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Configuration port, written only while the core is idle.
  logic     cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_LOW_LIMIT;
  val_t     cfg_data = '0;

  // Local copies of the channel drives so they are known from time zero.
  logic   tx_valid = 1'b0;
  frame_t tx_frame = '0;
  logic   rx_ready = 1'b0;

  rctm_in_if  in_ch ();
  rctm_out_if out_ch ();

  assign in_ch.valid     = tx_valid;
  assign in_ch.width_ch0 = tx_frame.w[0];
  assign in_ch.width_ch1 = tx_frame.w[1];
  assign in_ch.width_ch2 = tx_frame.w[2];
  assign in_ch.width_ch3 = tx_frame.w[3];
  assign out_ch.ready    = rx_ready;

  rc_channel_trimmed_mean_filter_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Sample sets waiting to be sent and filtered sets waiting to be seen.
  frame_t pending_frames[$];
  filt_t  expected_filt_q[$];

  // Filter state mirrored by the predictor.
  val_t       low_mdl;
  val_t       high_mdl;
  val_t       win_mdl [NCH][NSLOT];
  val_t       last_good_mdl [NCH];
  logic [1:0] slot_mdl;

  int unsigned tx_idle = 0;
  int unsigned rx_idle = 0;
  logic        stall_kick = 1'b0;
  int unsigned stall_left = 0;
  int unsigned err_cnt = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Advance the mirrored windows by one sample set and queue the filtered result.
  function automatic void predict_filter_step(frame_t f);
    val_t        kept;
    int unsigned sum;
    int unsigned hi;
    int unsigned lo;
    int unsigned trimmed [NCH];
    filt_t       res;
    slot_mdl = slot_mdl + 2'd1;
    for (int c = 0; c < NCH; c++) begin
      if (f.w[c] >= low_mdl && f.w[c] <= high_mdl) begin
        kept = f.w[c][VAL_W-1:0];
      end else begin
        kept = last_good_mdl[c];
      end
      win_mdl[c][slot_mdl] = kept;
      last_good_mdl[c] = kept;
      sum = 0;
      hi = 0;
      lo = 13'h1FFF;
      for (int k = 0; k < NSLOT; k++) begin
        if (win_mdl[c][k] > hi) hi = win_mdl[c][k];
        if (win_mdl[c][k] < lo) lo = win_mdl[c][k];
        sum += win_mdl[c][k];
      end
      trimmed[c] = ((sum - hi - lo) >> 1) & 32'h1FFF;
    end
    res.yaw      = trimmed[0][VAL_W-1:0];
    res.throttle = trimmed[1][VAL_W-1:0];
    res.roll     = trimmed[2][VAL_W-1:0];
    res.pitch    = trimmed[3][VAL_W-1:0];
    expected_filt_q.push_back(res);
  endfunction

  // Pulse width biased toward the accepted range and its edges.
  function automatic width_t pick_width(val_t lo, val_t hi);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70 && lo <= hi) return width_t'($urandom_range(hi, lo));
    if (r < 76) return width_t'(lo);
    if (r < 82) return width_t'(hi);
    if (r < 86) return width_t'(lo) - 16'd1;
    if (r < 90) return width_t'(hi) + 16'd1;
    return width_t'($urandom_range(16'hFFFF, 0));
  endfunction

  task automatic add_frame(width_t w0, width_t w1, width_t w2, width_t w3);
    frame_t f;
    f.w[0] = w0;
    f.w[1] = w1;
    f.w[2] = w2;
    f.w[3] = w3;
    pending_frames.push_back(f);
  endtask

  task automatic add_random_frames(int unsigned n, val_t lo, val_t hi);
    for (int i = 0; i < n; i++) begin
      add_frame(pick_width(lo, hi), pick_width(lo, hi), pick_width(lo, hi), pick_width(lo, hi));
    end
  endtask

  task automatic write_limit(cfg_idx_t idx, val_t value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      CFG_LOW_LIMIT:  low_mdl = value;
      CFG_HIGH_LIMIT: high_mdl = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every queued set has been sent and every result has been seen.
  task automatic drain();
    @(posedge clk);
    while (pending_frames.size() != 0 || tx_valid || expected_filt_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Sender: predicts on each accepted beat and offers the next set with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      tx_valid <= 1'b0;
    end else begin
      if (tx_valid && in_ch.ready) predict_filter_step(tx_frame);
      if (!tx_valid || in_ch.ready) begin
        if (pending_frames.size() != 0 && $urandom_range(99) >= tx_idle) begin
          tx_frame <= pending_frames.pop_front();
          tx_valid <= 1'b1;
        end else begin
          tx_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started by a one-cycle kick.
  always @(posedge clk) begin
    if (stall_kick) begin
      stall_left <= STALL_LEN;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Receiver: checks each result beat against the oldest prediction.
  always @(posedge clk) begin
    filt_t exp_f;
    filt_t got_f;
    if (!rst_n) begin
      rx_ready <= 1'b0;
    end else begin
      if (out_ch.valid && rx_ready) begin
        got_f.yaw      = out_ch.yaw_out;
        got_f.throttle = out_ch.throttle_out;
        got_f.roll     = out_ch.roll_out;
        got_f.pitch    = out_ch.pitch_out;
        if (expected_filt_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("%0t: result beat with nothing expected: yaw %0d thr %0d roll %0d pitch %0d",
                     $realtime, got_f.yaw, got_f.throttle, got_f.roll, got_f.pitch);
          end
        end else begin
          exp_f = expected_filt_q.pop_front();
          if (got_f.yaw != exp_f.yaw || got_f.throttle != exp_f.throttle ||
              got_f.roll != exp_f.roll || got_f.pitch != exp_f.pitch) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("%0t: mismatch yaw %0d/%0d thr %0d/%0d roll %0d/%0d pitch %0d/%0d (exp/got)",
                       $realtime, exp_f.yaw, got_f.yaw, exp_f.throttle, got_f.throttle,
                       exp_f.roll, got_f.roll, exp_f.pitch, got_f.pitch);
            end
          end
        end
      end
      rx_ready <= (stall_left == 0) && ($urandom_range(99) >= rx_idle);
    end
  end

  // Watchdog for a hung core.
  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

  // Test sequence: directed sets, then three random phases with different idling and a short random tail.
  initial begin
    val_t lo;
    val_t hi;
    low_mdl  = LOW_LIMIT_RST;
    high_mdl = HIGH_LIMIT_RST;
    slot_mdl = 2'd0;
    for (int c = 0; c < NCH; c++) begin
      last_good_mdl[c] = '0;
      for (int k = 0; k < NSLOT; k++) win_mdl[c][k] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Default limits: rejects before any good sample, inclusive edges, full-scale inputs.
    tx_idle <= 6;
    rx_idle <= 81;
    add_frame(16'd0, 16'd0, 16'd0, 16'd0);
    add_frame(16'd800, 16'd800, 16'd800, 16'd800);
    add_frame(16'd2800, 16'd2800, 16'd2800, 16'd2800);
    add_frame(16'd799, 16'd2801, 16'd799, 16'd2801);
    add_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_frame(16'd8191, 16'd8192, 16'd1500, 16'd0);
    add_frame(16'd1000, 16'd2000, 16'd1200, 16'd2700);
    add_frame(16'd1800, 16'd900, 16'd2500, 16'd1100);
    drain();

    // Widest limits: every 13-bit value passes, anything above does not.
    write_limit(CFG_LOW_LIMIT, 13'd0);
    write_limit(CFG_HIGH_LIMIT, 13'h1FFF);
    add_frame(16'd8191, 16'd0, 16'd8191, 16'd0);
    add_frame(16'd8192, 16'hFFFF, 16'd4096, 16'd1);
    add_frame(16'hAAAA, 16'h5555, 16'd8190, 16'd2);
    add_frame(16'd0, 16'd8191, 16'd0, 16'd8191);
    add_frame(16'd8191, 16'd8191, 16'd8191, 16'd8191);
    drain();

    // Crossed limits: every channel keeps repeating its last accepted sample.
    write_limit(CFG_LOW_LIMIT, 13'd3000);
    write_limit(CFG_HIGH_LIMIT, 13'd1000);
    add_frame(16'd2000, 16'd3000, 16'd1000, 16'd0);
    add_frame(16'd1500, 16'd500, 16'd5000, 16'hFFFF);
    add_frame(16'd3000, 16'd1000, 16'd2999, 16'd1001);
    drain();

    // Single-value window of acceptance.
    write_limit(CFG_LOW_LIMIT, 13'd1234);
    write_limit(CFG_HIGH_LIMIT, 13'd1234);
    add_frame(16'd1234, 16'd1233, 16'd1235, 16'd1234);
    add_frame(16'd1233, 16'd1234, 16'd1234, 16'd1235);
    add_frame(16'd1234, 16'd1234, 16'd1234, 16'd1234);
    drain();

    // Random phase with a mostly idle receiver at the default limits.
    tx_idle <= 6;
    rx_idle <= 81;
    write_limit(CFG_LOW_LIMIT, LOW_LIMIT_RST);
    write_limit(CFG_HIGH_LIMIT, HIGH_LIMIT_RST);
    add_random_frames(330, LOW_LIMIT_RST, HIGH_LIMIT_RST);
    drain();

    // Random phase with a mostly idle sender and random ordered limits.
    tx_idle <= 81;
    rx_idle <= 6;
    lo = val_t'($urandom_range(4000, 0));
    hi = val_t'($urandom_range(13'h1FFF, lo));
    write_limit(CFG_LOW_LIMIT, lo);
    write_limit(CFG_HIGH_LIMIT, hi);
    add_random_frames(330, lo, hi);
    drain();

    // No idling at the widest limits, with a long receiver hold-off to back up the input.
    tx_idle <= 0;
    rx_idle <= 0;
    write_limit(CFG_LOW_LIMIT, 13'd0);
    write_limit(CFG_HIGH_LIMIT, 13'h1FFF);
    add_random_frames(280, 13'd0, 13'h1FFF);
    @(posedge clk);
    stall_kick <= 1'b1;
    @(posedge clk);
    stall_kick <= 1'b0;
    drain();

    // Short random tail with crossed limits.
    lo = val_t'($urandom_range(13'h1FFF, 4096));
    hi = val_t'($urandom_range(4095, 0));
    write_limit(CFG_LOW_LIMIT, lo);
    write_limit(CFG_HIGH_LIMIT, hi);
    add_random_frames(60, hi, lo);
    drain();

    repeat (5) @(posedge clk);
    if (err_cnt == 0 && expected_filt_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
